// File: sv/assert_macros.svh
// assertion macros shared by the grid dilation rtl
// expects signals named clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define BGBD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BGBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bgbd_pkg.sv
// shared types and constants of the binary grid box dilation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bgbd_pkg;

  // default grid storage size
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // field widths fixed by the interface
  localparam int REQ_W = 2;
  localparam int IDX_W = 6;
  localparam int OCC_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // answer codes
  localparam logic [OCC_W-1:0] OCC_EMPTY    = 2'd0;
  localparam logic [OCC_W-1:0] OCC_OCCUPIED = 2'd1;
  localparam logic [OCC_W-1:0] OCC_UNKNOWN  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIL_COLS = 2'd3;

  // controller states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_READ   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;      // latch the input item
    logic clear;     // empty the whole grid
    logic setup;     // compute bounds, read the item's row
    logic wr;        // write back the modified row
    logic rd;        // read the row under the pointer
    logic load_out;  // load the answer into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_grid;   // item lies inside the grid in use
    logic last_row;  // pointer is at the last row of the window
    logic out_free;  // output register can take a new answer
  } stat_t;

endpackage

`default_nettype wire

// File: sv/bgbd_ctrl.sv
// controller state machine of the grid dilation block
// depends on bgbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgbd_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [bgbd_pkg::REQ_W-1:0] req_type,
  input  wire bgbd_pkg::stat_t           stat,
  output bgbd_pkg::cmd_t                 cmd
);
  import bgbd_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_query;
  logic   accept;

  // input transfers only in idle
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // state register and request kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      is_query <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        is_query <= (req_type == REQ_QUERY);
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = accept;
        if (accept) begin
          case (req_type)
            REQ_WRITE: state_next = ST_SETUP;
            REQ_QUERY: state_next = ST_SETUP;
            REQ_CLEAR: cmd.clear  = 1'b1;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = is_query ? ST_READ : ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (!stat.in_grid) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd = 1'b1;
          if (stat.last_row) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bgbd_datapath.sv
// datapath of the grid dilation block: config registers, row memory,
// window bounds, row accumulation and output register; depends on bgbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgbd_datapath #(
  parameter int MAX_ROWS = bgbd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bgbd_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bgbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bgbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [bgbd_pkg::IDX_W-1:0]      row,
  input  wire logic [bgbd_pkg::IDX_W-1:0]      col,
  input  wire logic                           occupied,
  input  wire bgbd_pkg::cmd_t                 cmd,
  output bgbd_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bgbd_pkg::OCC_W-1:0]           occupancy
);
  import bgbd_pkg::*;

  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int RW  = (NRW > 7) ? NRW : 7;
  localparam int XW  = (AW > IDX_W) ? AW : IDX_W;

  // configuration registers
  logic [6:0] num_rows;
  logic [6:0] num_cols;
  logic [5:0] dil_rows;
  logic [5:0] dil_cols;

  // latched item
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic             occ_q;

  // window state
  logic                in_grid;
  logic [AW-1:0]       ptr;
  logic [AW-1:0]       rhi;
  logic [MAX_COLS-1:0] mask;
  logic                acc_hit;
  logic                rd_pend;

  // row memory, per-row valid bits and registered read
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_COLS-1:0] rd_data;
  logic                rd_valid;
  logic [AW-1:0]       rd_addr;
  logic [MAX_COLS-1:0] wr_word;
  logic                wr_en;

  // combinational bounds
  logic [RW-1:0]       nr;
  logic [6:0]          nc;
  logic                in_grid_next;
  logic [IDX_W-1:0]    rlo6;
  logic [RW-1:0]       rsum;
  logic [RW-1:0]       rlim;
  logic [RW-1:0]       rhi_w;
  logic [IDX_W-1:0]    clo;
  logic [6:0]          csum;
  logic [6:0]          clim;
  logic [6:0]          chi;
  logic [MAX_COLS-1:0] mask_next;
  logic [XW-1:0]       row_x;
  logic [XW-1:0]       rlo_x;
  logic [MAX_COLS-1:0] base_word;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 7'd1;
      num_cols <= 7'd1;
      dil_rows <= 6'd0;
      dil_cols <= 6'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data;
        CFG_DIL_ROWS: dil_rows <= cfg_data[5:0];
        CFG_DIL_COLS: dil_cols <= cfg_data[5:0];
        default:      num_rows <= num_rows;
      endcase
    end
  end

  // grid size in use, clamped to 1..max
  always_comb begin
    if (num_rows == 7'd0) begin
      nr = RW'(1);
    end else if (RW'(num_rows) > RW'(MAX_ROWS)) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(num_rows);
    end
    if (num_cols == 7'd0) begin
      nc = 7'd1;
    end else if (num_cols > 7'(MAX_COLS)) begin
      nc = 7'(MAX_COLS);
    end else begin
      nc = num_cols;
    end
  end

  // window bounds clipped to the grid
  always_comb begin
    in_grid_next = (RW'(row_q) < nr) && ({1'b0, col_q} < nc);
    rlo6  = (row_q >= dil_rows) ? (row_q - dil_rows) : '0;
    rsum  = RW'(row_q) + RW'(dil_rows);
    rlim  = nr - RW'(1);
    rhi_w = (rsum > rlim) ? rlim : rsum;
    clo   = (col_q >= dil_cols) ? (col_q - dil_cols) : '0;
    csum  = {1'b0, col_q} + {1'b0, dil_cols};
    clim  = nc - 7'd1;
    chi   = (csum > clim) ? clim : csum;
    for (int i = 0; i < MAX_COLS; i++) begin
      mask_next[i] = (7'(i) >= {1'b0, clo}) && (7'(i) <= chi);
    end
    row_x = XW'(row_q);
    rlo_x = XW'(rlo6);
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_q <= row;
      col_q <= col;
      occ_q <= occupied;
    end
  end

  // window registers and row pointer
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      in_grid <= in_grid_next;
      ptr     <= rlo_x[AW-1:0];
      rhi     <= rhi_w[AW-1:0];
      mask    <= mask_next;
    end else if (cmd.rd) begin
      ptr <= ptr + AW'(1);
    end
  end

  // read address: item row for a write, pointer for a query
  assign rd_addr = cmd.setup ? row_x[AW-1:0] : ptr;

  // memory read, registered together with the row valid bit
  always_ff @(posedge clk) begin
    rd_data  <= mem[rd_addr];
    rd_valid <= row_valid[rd_addr];
  end

  // modified row for a raw write
  always_comb begin
    base_word = rd_valid ? rd_data : '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      wr_word[i] = (IDX_W'(i) == col_q) ? occ_q : base_word[i];
    end
  end

  assign wr_en = cmd.wr && in_grid;

  // memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_x[AW-1:0]] <= wr_word;
    end
  end

  // row valid bits, cleared by reset and clear items
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[row_x[AW-1:0]] <= 1'b1;
    end
  end

  // OR of the masked rows, one row per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      acc_hit <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
      if (cmd.setup) begin
        acc_hit <= 1'b0;
      end else if (rd_pend && rd_valid && ((rd_data & mask) != '0)) begin
        acc_hit <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      occupancy <= !in_grid ? OCC_UNKNOWN : (acc_hit ? OCC_OCCUPIED : OCC_EMPTY);
    end
  end

  // status
  assign stat.in_grid  = in_grid;
  assign stat.last_row = (ptr == rhi);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// File: sv/binary_grid_box_dilation.sv
// channel  dir  transfer when          payload
// in       in   in_valid & !in_stall   req_type, row, col, occupied
// out      out  out_valid & !out_stall occupancy
// cfg      in   cfg_write              cfg_index, cfg_data
//
// a clear completes in idle; a write reads, modifies and writes back one row
// a query reads the window rows, clipped to the grid, one by one through
// the single read port of the row memory; a query outside the grid reads none
// reset empties the grid at once through per-row valid bits, no clearing pass
// a stalled answer holds the block in its final query cycle until transferred
//
// top level of the binary grid box dilation block; depends on bgbd_pkg,
// bgbd_ctrl, bgbd_datapath and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binary_grid_box_dilation #(
  parameter int MAX_ROWS = bgbd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bgbd_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bgbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bgbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bgbd_pkg::REQ_W-1:0]      req_type,
  input  wire logic [bgbd_pkg::IDX_W-1:0]      row,
  input  wire logic [bgbd_pkg::IDX_W-1:0]      col,
  input  wire logic                           occupied,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bgbd_pkg::OCC_W-1:0]           occupancy
);
  import bgbd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  bgbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  bgbd_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row       (row),
    .col       (col),
    .occupied  (occupied),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .occupancy (occupancy)
  );

  // checks
  `BGBD_ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.take, cmd.setup, cmd.wr, cmd.rd, cmd.load_out}), "overlapping datapath commands")
  `BGBD_ASSERT_SAME(a_load_free, cmd.load_out, stat.out_free, "answer loaded over a waiting result")
  `BGBD_ASSERT_SAME(a_occ_code, out_valid, occupancy != 2'd3, "invalid occupancy code")
  `BGBD_ASSERT_NEXT(a_write_busy, in_valid && !in_stall && (req_type == REQ_WRITE), in_stall, "write transfer did not start row update")

endmodule

`default_nettype wire
